@@ design/cleaning_robot_obstacle_sequencer_assert.svh @@
// Assertion macros shared by the obstacle sequencer RTL.
// Each macro expects clk and arst_n in scope; no other dependencies.
`ifndef CLEANING_ROBOT_OBSTACLE_SEQUENCER_ASSERT_SVH
`define CLEANING_ROBOT_OBSTACLE_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define CROBS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CROBS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/crobs_pkg.sv @@
// Shared types and codes for the cleaning robot obstacle sequencer.
// No dependencies; imported by every other design file but the assertion macro header.
package crobs_pkg;

	localparam int CNT_W  = 10;
	localparam int CODE_W = 3;
	localparam int IDX_W  = 2;

	// event codes
	localparam logic [CODE_W-1:0] EV_ENTER    = 3'd0;
	localparam logic [CODE_W-1:0] EV_SETUP    = 3'd1;
	localparam logic [CODE_W-1:0] EV_STALL    = 3'd2;
	localparam logic [CODE_W-1:0] EV_OBSTACLE = 3'd3;
	localparam logic [CODE_W-1:0] EV_ESCAPE   = 3'd4;

	// motor commands
	localparam logic [1:0] MOT_FWD  = 2'd0;
	localparam logic [1:0] MOT_STOP = 2'd1;
	localparam logic [1:0] MOT_REV  = 2'd2;
	localparam logic [1:0] MOT_SPIN = 2'd3;

	// display messages
	localparam logic [1:0] DSP_CLEAN  = 2'd0;
	localparam logic [1:0] DSP_AVOID  = 2'd1;
	localparam logic [1:0] DSP_NORMAL = 2'd2;

	// link messages
	localparam logic LNK_STALL   = 1'b0;
	localparam logic LNK_COLLIDE = 1'b1;

	// mode requests
	localparam logic MODE_SETUP = 1'b0;
	localparam logic MODE_FAULT = 1'b1;

	// register indexes
	localparam logic [IDX_W-1:0] REG_STOP    = 2'd0;
	localparam logic [IDX_W-1:0] REG_REVERSE = 2'd1;
	localparam logic [IDX_W-1:0] REG_SPIN    = 2'd2;

	localparam logic [CNT_W-1:0] STOP_RST    = 10'd200;
	localparam logic [CNT_W-1:0] REVERSE_RST = 10'd500;
	localparam logic [CNT_W-1:0] SPIN_RST    = 10'd800;

	typedef struct packed {
		logic [CNT_W-1:0] stop_ticks;
		logic [CNT_W-1:0] reverse_ticks;
		logic [CNT_W-1:0] spin_ticks;
	} cfg_t;

	typedef struct packed {
		logic       motor_cmd_valid;
		logic [1:0] motor_cmd;
		logic       display_msg_valid;
		logic [1:0] display_msg;
		logic       link_msg_valid;
		logic       link_msg;
		logic       mode_req_valid;
		logic       mode_req;
		logic [1:0] cur_state;
	} res_t;

endpackage

@@ design/crobs_if.sv @@
// Valid/ready channel interfaces: event input and command result.
// Depends on crobs_pkg for widths.
interface crobs_ev_if;
	import crobs_pkg::*;
	logic              valid;
	logic              ready;
	logic              event_valid;
	logic [CODE_W-1:0] event_code;

	modport source (output valid, event_valid, event_code, input ready);
	modport sink   (input valid, event_valid, event_code, output ready);
endinterface

interface crobs_res_if;
	logic       valid;
	logic       ready;
	logic       motor_cmd_valid;
	logic [1:0] motor_cmd;
	logic       display_msg_valid;
	logic [1:0] display_msg;
	logic       link_msg_valid;
	logic       link_msg;
	logic       mode_req_valid;
	logic       mode_req;
	logic [1:0] cur_state;

	modport source (output valid, motor_cmd_valid, motor_cmd, display_msg_valid, display_msg,
		link_msg_valid, link_msg, mode_req_valid, mode_req, cur_state, input ready);
	modport sink (input valid, motor_cmd_valid, motor_cmd, display_msg_valid, display_msg,
		link_msg_valid, link_msg, mode_req_valid, mode_req, cur_state, output ready);
endinterface

@@ design/crobs_cfg.sv @@
// Phase length registers, written through the plain configuration port.
// Depends on crobs_pkg.
module crobs_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        we,
	input  logic [crobs_pkg::IDX_W-1:0] idx,
	input  logic [crobs_pkg::CNT_W-1:0] data,
	output crobs_pkg::cfg_t             cfg
);
	import crobs_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_ticks    <= STOP_RST;
			cfg_q.reverse_ticks <= REVERSE_RST;
			cfg_q.spin_ticks    <= SPIN_RST;
		end else if (we) begin
			unique case (idx)
				REG_STOP:    cfg_q.stop_ticks    <= data;
				REG_REVERSE: cfg_q.reverse_ticks <= data;
				REG_SPIN:    cfg_q.spin_ticks    <= data;
				default:     ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/crobs_fsm.sv @@
// Idle/cleaning/avoiding controller with phase countdown and result register.
// Depends on crobs_pkg and the assertion macro header.
`include "cleaning_robot_obstacle_sequencer_assert.svh"

module crobs_fsm (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic                         ev_valid,
	input  logic [crobs_pkg::CODE_W-1:0] ev_code,
	input  crobs_pkg::cfg_t              cfg,
	output crobs_pkg::res_t              res
);
	import crobs_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_CLEAN = 2'd1,
		ST_AVOID = 2'd2
	} state_t;

	typedef enum logic [1:0] {
		PH_STOP = 2'd0,
		PH_REV  = 2'd1,
		PH_SPIN = 2'd2
	} phase_t;

	state_t           state_q, state_d;
	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] cd_q, cd_d, cd_dec;
	res_t             res_q, res_d;

	// countdown ticks down before the state logic looks at it
	assign cd_dec = (cd_q == '0) ? cd_q : cd_q - 1'b1;

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cd_d    = cd_dec;
		res_d   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (ev_valid && ev_code == EV_ENTER) begin
					state_d                 = ST_CLEAN;
					res_d.display_msg_valid = 1'b1;
					res_d.display_msg       = DSP_CLEAN;
					res_d.motor_cmd_valid   = 1'b1;
					res_d.motor_cmd         = MOT_FWD;
				end else if (ev_valid && ev_code == EV_SETUP) begin
					res_d.mode_req_valid = 1'b1;
					res_d.mode_req       = MODE_SETUP;
				end
			end
			ST_CLEAN: begin
				if (ev_valid && ev_code == EV_STALL) begin
					state_d              = ST_IDLE;
					res_d.mode_req_valid = 1'b1;
					res_d.mode_req       = MODE_FAULT;
					res_d.link_msg_valid = 1'b1;
					res_d.link_msg       = LNK_STALL;
				end else if (ev_valid && ev_code == EV_OBSTACLE) begin
					state_d                 = ST_AVOID;
					phase_d                 = PH_STOP;
					cd_d                    = cfg.stop_ticks;
					res_d.display_msg_valid = 1'b1;
					res_d.display_msg       = DSP_AVOID;
					res_d.motor_cmd_valid   = 1'b1;
					res_d.motor_cmd         = MOT_STOP;
					res_d.link_msg_valid    = 1'b1;
					res_d.link_msg          = LNK_COLLIDE;
				end else if (ev_valid && ev_code == EV_ESCAPE) begin
					state_d                 = ST_IDLE;
					res_d.motor_cmd_valid   = 1'b1;
					res_d.motor_cmd         = MOT_STOP;
					res_d.display_msg_valid = 1'b1;
					res_d.display_msg       = DSP_NORMAL;
				end
			end
			ST_AVOID: begin
				// stall wins over a phase advance in the same tick
				if (ev_valid && ev_code == EV_STALL) begin
					state_d              = ST_IDLE;
					res_d.mode_req_valid = 1'b1;
					res_d.mode_req       = MODE_FAULT;
				end else if (cd_dec == '0) begin
					res_d.motor_cmd_valid = 1'b1;
					unique case (phase_q)
						PH_STOP: begin
							phase_d         = PH_REV;
							cd_d            = cfg.reverse_ticks;
							res_d.motor_cmd = MOT_REV;
						end
						PH_REV: begin
							phase_d         = PH_SPIN;
							cd_d            = cfg.spin_ticks;
							res_d.motor_cmd = MOT_SPIN;
						end
						default: begin
							state_d                 = ST_CLEAN;
							res_d.display_msg_valid = 1'b1;
							res_d.display_msg       = DSP_CLEAN;
							res_d.motor_cmd         = MOT_FWD;
						end
					endcase
				end
			end
			default: state_d = ST_IDLE;
		endcase
		res_d.cur_state = state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_STOP;
			cd_q    <= '0;
			res_q   <= '0;
		end else if (step) begin
			state_q <= state_d;
			phase_q <= phase_d;
			cd_q    <= cd_d;
			res_q   <= res_d;
		end
	end

	assign res = res_q;

	`CROBS_ASSERT_NXT(a_no_step_hold, !step,
		$stable(state_q) && $stable(cd_q) && $stable(res_q), "controller moved without a step")
	`CROBS_ASSERT_NXT(a_stall_avoid_idle,
		step && state_q == ST_AVOID && ev_valid && ev_code == EV_STALL,
		state_q == ST_IDLE && res_q.mode_req == MODE_FAULT && !res_q.motor_cmd_valid,
		"stall in avoiding did not go idle")
	`CROBS_ASSERT_IMP(a_state_matches, 1'b1, res_q.cur_state == state_q,
		"reported state differs from controller state")

endmodule

@@ design/cleaning_robot_obstacle_sequencer.sv @@
// Top level of the cleaning robot obstacle sequencer: input register, controller, result.
// Depends on crobs_pkg, crobs_if, crobs_cfg, crobs_fsm and the assertion macro header.
//
//   channel   dir   handshake        payload
//   ev_in     in    valid/ready      event_valid, event_code
//   res_out   out   valid/ready      motor/display/link/mode commands, cur_state
//   cfg       in    we (no wait)     idx, data (phase lengths)
//
// One tick per clock sustained while res_out.ready holds; two registers (input register, result register).
// The controller state advances in the cycle a registered tick moves into the result register.
// A stalled result holds; one more tick waits in the input register, then ev_in.ready drops.
// Reset clears control state and loads phase lengths 200/500/800; no clearing pass.
`include "cleaning_robot_obstacle_sequencer_assert.svh"

module cleaning_robot_obstacle_sequencer (
	input  logic                        clk,
	input  logic                        arst_n,
	crobs_ev_if.sink                    ev_in,
	crobs_res_if.source                 res_out,
	input  logic                        cfg_we,
	input  logic [crobs_pkg::IDX_W-1:0] cfg_idx,
	input  logic [crobs_pkg::CNT_W-1:0] cfg_data
);
	import crobs_pkg::*;

	logic              valid_s1;
	logic              ev_valid_s1;
	logic [CODE_W-1:0] ev_code_s1;
	logic              res_valid_q;
	logic              step;
	cfg_t              cfg;
	res_t              res;

	assign step        = valid_s1 && (!res_valid_q || res_out.ready);
	assign ev_in.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (ev_in.ready)
				valid_s1 <= ev_in.valid;
			if (step)
				res_valid_q <= 1'b1;
			else if (res_out.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_in.valid && ev_in.ready) begin
			ev_valid_s1 <= ev_in.event_valid;
			ev_code_s1  <= ev_in.event_code;
		end
	end

	crobs_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.idx    (cfg_idx),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	crobs_fsm u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.ev_valid (ev_valid_s1),
		.ev_code  (ev_code_s1),
		.cfg      (cfg),
		.res      (res)
	);

	assign res_out.valid             = res_valid_q;
	assign res_out.motor_cmd_valid   = res.motor_cmd_valid;
	assign res_out.motor_cmd         = res.motor_cmd;
	assign res_out.display_msg_valid = res.display_msg_valid;
	assign res_out.display_msg       = res.display_msg;
	assign res_out.link_msg_valid    = res.link_msg_valid;
	assign res_out.link_msg          = res.link_msg;
	assign res_out.mode_req_valid    = res.mode_req_valid;
	assign res_out.mode_req          = res.mode_req;
	assign res_out.cur_state         = res.cur_state;

	`CROBS_ASSERT_IMP(a_stall_means_full, !ev_in.ready,
		valid_s1 && res_valid_q && !res_out.ready, "input stalled with a free slot")

endmodule
